// ===== sv/lnedit_pkg.sv =====
package lnedit_pkg;

	localparam int LINE_DEPTH_DEF = 63;
	localparam int FILL_W         = 6;
	localparam int CFG_IDX_W      = 2;

	localparam logic [7:0] ERASE_RST    = 8'd35;
	localparam logic [7:0] KILL_RST     = 8'd64;
	localparam logic [7:0] LINE_END_RST = 8'd10;

	localparam logic [CFG_IDX_W-1:0] CFG_ERASE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KILL     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_END = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       truncated;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_CLOSE
	} state_t;

endpackage

// ===== sv/lnedit_ram.sv =====
module lnedit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = lnedit_pkg::LINE_DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data between reads
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/line_editor_erase_kill.sv =====
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_ready    in_data   (lnedit_pkg::in_item_t)
// out      out  out_valid / out_ready  out_data  (lnedit_pkg::out_item_t)
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An editing byte or a byte that is stored or dropped leaves in_ready high.
// A line end (or end of text on an open line) holds in_ready low while the
// line is walked out of the line memory: each stored byte is read, then
// loaded into the output register, and then the closing byte is loaded;
// loads wait while out_valid is high and out_ready is low. cfg_ready is held
// low over the same span.
// Reset clears the counters and flags at once; the line memory is not cleared.
module line_editor_erase_kill #(
	parameter int LINE_DEPTH = lnedit_pkg::LINE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  lnedit_pkg::in_item_t                 in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output lnedit_pkg::out_item_t                out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lnedit_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [7:0]                           cfg_data
);

	localparam int AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam logic [lnedit_pkg::FILL_W-1:0] FILL_MAX = lnedit_pkg::FILL_W'(LINE_DEPTH);

	lnedit_pkg::state_t state_q, state_d;

	logic [7:0] erase_q, kill_q, line_end_q;
	logic [lnedit_pkg::FILL_W-1:0] fill_q, fill_d;
	logic [lnedit_pkg::FILL_W-1:0] rd_idx_q, rd_idx_d;
	logic open_q, open_d;
	logic dropped_q, dropped_d;

	logic out_valid_q;
	lnedit_pkg::out_item_t out_q, out_d;
	logic out_load;
	logic out_free;

	logic in_fire;
	logic ram_we, ram_re;
	logic [7:0] ram_rdata;
	logic [lnedit_pkg::FILL_W-1:0] rd_idx_inc;

	assign in_ready  = (state_q == lnedit_pkg::ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	// hold off register writes while a line is walked out
	assign cfg_ready = (state_q == lnedit_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign out_free  = !out_valid_q || out_ready;
	assign rd_idx_inc = rd_idx_q + 1'b1;

	lnedit_ram #(
		.WIDTH (8),
		.DEPTH (LINE_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[AW-1:0]),
		.wdata (in_data.in_byte),
		.re    (ram_re),
		.raddr (rd_idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		rd_idx_d  = rd_idx_q;
		open_d    = open_q;
		dropped_d = dropped_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		out_load  = 1'b0;
		out_d     = out_q;
		case (state_q)
			lnedit_pkg::ST_IDLE: begin
				if (in_fire) begin
					if (in_data.end_of_text || in_data.in_byte == line_end_q) begin
						if (!in_data.end_of_text || open_q) begin
							rd_idx_d = '0;
							state_d  = (fill_q == '0) ? lnedit_pkg::ST_CLOSE
							                          : lnedit_pkg::ST_READ;
						end
					end else begin
						open_d = 1'b1;
						if (in_data.in_byte == erase_q) begin
							if (fill_q != '0) begin
								fill_d = fill_q - 1'b1;
							end
						end else if (in_data.in_byte == kill_q) begin
							fill_d    = '0;
							dropped_d = 1'b0;
						end else if (fill_q < FILL_MAX) begin
							ram_we = 1'b1;
							fill_d = fill_q + 1'b1;
						end else begin
							dropped_d = 1'b1;
						end
					end
				end
			end
			lnedit_pkg::ST_READ: begin
				ram_re  = 1'b1;
				state_d = lnedit_pkg::ST_LOAD;
			end
			lnedit_pkg::ST_LOAD: begin
				if (out_free) begin
					out_load = 1'b1;
					out_d    = '{out_byte: ram_rdata, last: 1'b0, truncated: dropped_q};
					rd_idx_d = rd_idx_inc;
					state_d  = (rd_idx_inc == fill_q) ? lnedit_pkg::ST_CLOSE
					                                  : lnedit_pkg::ST_READ;
				end
			end
			lnedit_pkg::ST_CLOSE: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_d     = '{out_byte: line_end_q, last: 1'b1, truncated: dropped_q};
					fill_d    = '0;
					open_d    = 1'b0;
					dropped_d = 1'b0;
					state_d   = lnedit_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lnedit_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lnedit_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rd_idx_q    <= '0;
			open_q      <= 1'b0;
			dropped_q   <= 1'b0;
			out_valid_q <= 1'b0;
			erase_q     <= lnedit_pkg::ERASE_RST;
			kill_q      <= lnedit_pkg::KILL_RST;
			line_end_q  <= lnedit_pkg::LINE_END_RST;
		end else begin
			fill_q    <= fill_d;
			rd_idx_q  <= rd_idx_d;
			open_q    <= open_d;
			dropped_q <= dropped_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lnedit_pkg::CFG_ERASE:    erase_q    <= cfg_data;
					lnedit_pkg::CFG_KILL:     kill_q     <= cfg_data;
					lnedit_pkg::CFG_LINE_END: line_end_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("fill count beyond line depth");

	a_no_write_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> state_q == lnedit_pkg::ST_IDLE && in_fire)
		else $error("line memory written outside an input transfer");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lnedit_pkg::ST_READ || state_q == lnedit_pkg::ST_LOAD)
			|-> rd_idx_q < fill_q)
		else $error("read index past buffered bytes");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lnedit_pkg::ST_CLOSE && out_load)
			|=> state_q == lnedit_pkg::ST_IDLE && fill_q == '0 && !open_q && !dropped_q
				&& out_valid_q && out_q.last)
		else $error("closing transfer did not clear the line");

endmodule
